[hw/rtl/vpcf_pkg.sv]
package vpcf_pkg;

	localparam int MAT_W     = 16;
	localparam int ROW_W     = 3 * MAT_W;
	localparam int VEC_W     = 32;
	localparam int TS_W      = 24;
	localparam int BW_W      = 17;
	localparam int GR_W      = 20;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	localparam int MA_W   = 33;
	localparam int MB_W   = 25;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = 62;
	localparam int S10_W  = 38;
	localparam int SPLIT  = 19;
	localparam int SUM_W  = 44;
	localparam int GR_SH  = 14;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BLEND     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = CFG_IDX_W'(2);

	localparam logic [TS_W-1:0] TS_RESET = TS_W'(41943);
	localparam logic [BW_W-1:0] BW_RESET = BW_W'(6554);
	localparam logic [GR_W-1:0] GR_RESET = GR_W'(642253);
	localparam logic [BW_W-1:0] W_ONE    = BW_W'(65536);

	localparam logic signed [ACC_W-1:0] RND20 = ACC_W'(1) <<< 19;
	localparam logic signed [ACC_W-1:0] RND18 = ACC_W'(1) <<< 17;
	localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(1) <<< 15;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRED,
		ST_CORR
	} state_t;

	typedef logic [3:0] step_t;
	typedef logic [1:0] axis_t;

	localparam axis_t AXIS_FIRST = axis_t'(0);
	localparam axis_t AXIS_LAST  = axis_t'(2);

	localparam step_t P_MUL0  = step_t'(0);
	localparam step_t P_MUL1  = step_t'(1);
	localparam step_t P_MUL2  = step_t'(2);
	localparam step_t P_SUM   = step_t'(3);
	localparam step_t P_SCALE = step_t'(4);
	localparam step_t P_S10   = step_t'(5);
	localparam step_t P_TSHI  = step_t'(6);
	localparam step_t P_TSLO  = step_t'(7);
	localparam step_t P_PROD  = step_t'(8);
	localparam step_t P_DELTA = step_t'(9);
	localparam step_t P_KEEP  = step_t'(10);

	localparam step_t C_MULK = step_t'(0);
	localparam step_t C_MULR = step_t'(1);
	localparam step_t C_SUM  = step_t'(2);
	localparam step_t C_OUT  = step_t'(3);

	typedef struct packed {
		logic item_ready;
		logic advance;
		logic step_last;
	} seq_ctl_t;

	function automatic logic signed [VEC_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [VEC_W-1:0] r;
		if (x[SUM_W-1:VEC_W-1] == '0 || x[SUM_W-1:VEC_W-1] == '1) begin
			r = x[VEC_W-1:0];
		end else if (x[SUM_W-1]) begin
			r = {1'b1, {(VEC_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VEC_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[hw/rtl/vpcf_if.sv]
interface vpcf_item_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic        [vpcf_pkg::ROW_W-1:0]  rot_row0;
	logic        [vpcf_pkg::ROW_W-1:0]  rot_row1;
	logic        [vpcf_pkg::ROW_W-1:0]  rot_row2;
	logic signed [vpcf_pkg::VEC_W-1:0]  vec_x;
	logic signed [vpcf_pkg::VEC_W-1:0]  vec_y;
	logic signed [vpcf_pkg::VEC_W-1:0]  vec_z;

	modport source(output valid, func, rot_row0, rot_row1, rot_row2, vec_x, vec_y, vec_z,
		input ready);
	modport sink(input valid, func, rot_row0, rot_row1, rot_row2, vec_x, vec_y, vec_z,
		output ready);
endinterface

interface vpcf_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [vpcf_pkg::VEC_W-1:0]  vel_x;
	logic signed [vpcf_pkg::VEC_W-1:0]  vel_y;
	logic signed [vpcf_pkg::VEC_W-1:0]  vel_z;

	modport source(output valid, vel_x, vel_y, vel_z, input ready);
	modport sink(input valid, vel_x, vel_y, vel_z, output ready);
endinterface

[hw/rtl/velocity_predict_correct_filter_core.sv]
// Predict item: 3 axes x 11 steps, no result.
// Correct item: result valid after its 3 axes x 4 steps, plus any wait
// for the output register to empty at the start of the item.
// A new item is taken only while idle, once the previous item's sequence has ended, as set
// by the single 33x25 multiplier and accumulator shared by all steps of the sequencer.
// Reset (arst_n low, async): idle, output empty, kept velocity zero, registers to defaults.
module velocity_predict_correct_filter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	vpcf_item_if.sink                             item_ch,
	vpcf_result_if.source                         result_ch,
	input  logic                                  cfg_we,
	input  logic [vpcf_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [vpcf_pkg::CFG_W-1:0]            cfg_data
);

	vpcf_pkg::state_t state_q, state_d;
	vpcf_pkg::step_t  step_q;
	vpcf_pkg::axis_t  axis_q;
	vpcf_pkg::seq_ctl_t ctl;

	logic [vpcf_pkg::TS_W-1:0] ts_q;
	logic [vpcf_pkg::BW_W-1:0] bw_q;
	logic [vpcf_pkg::GR_W-1:0] gr_q;

	logic signed [vpcf_pkg::VEC_W-1:0] kept_q [3];
	logic        [vpcf_pkg::ROW_W-1:0] rot_q  [3];
	logic signed [vpcf_pkg::VEC_W-1:0] vec_q  [3];
	logic signed [vpcf_pkg::VEC_W-1:0] vel_q  [3];
	logic                              out_valid_q;

	logic signed [vpcf_pkg::PROD_W-1:0] p_q;
	logic signed [vpcf_pkg::ACC_W-1:0]  acc_q;
	logic signed [vpcf_pkg::S10_W-1:0]  s10_q;

	logic signed [vpcf_pkg::MA_W-1:0]   mul_a;
	logic signed [vpcf_pkg::MB_W-1:0]   mul_b;
	logic signed [vpcf_pkg::PROD_W-1:0] prod;
	logic        [vpcf_pkg::BW_W-1:0]   w;
	logic        [1:0]                  col;
	logic                               neg;
	logic signed [vpcf_pkg::ACC_W-1:0]  pterm;
	logic signed [vpcf_pkg::ACC_W-1:0]  pterm_s;
	logic signed [vpcf_pkg::ACC_W-1:0]  grav_term;
	logic                               item_xfer;
	logic                               result_xfer;

	assign item_xfer   = item_ch.valid && item_ch.ready;
	assign result_xfer = result_ch.valid && result_ch.ready;

	assign w         = (bw_q > vpcf_pkg::W_ONE) ? vpcf_pkg::W_ONE : bw_q;
	assign col       = step_q[1:0];
	assign neg       = (axis_q == vpcf_pkg::AXIS_LAST);
	assign pterm     = vpcf_pkg::ACC_W'(p_q);
	assign pterm_s   = neg ? -pterm : pterm;
	assign grav_term = {{(vpcf_pkg::ACC_W-vpcf_pkg::GR_W-vpcf_pkg::GR_SH){1'b0}}, gr_q,
		{vpcf_pkg::GR_SH{1'b0}}};

	// sequencer control
	always_comb begin
		ctl = '0;
		case (state_q)
			vpcf_pkg::ST_IDLE: begin
				ctl.item_ready = 1'b1;
			end
			vpcf_pkg::ST_PRED: begin
				ctl.advance   = 1'b1;
				ctl.step_last = (step_q == vpcf_pkg::P_KEEP);
			end
			vpcf_pkg::ST_CORR: begin
				ctl.advance   = !(out_valid_q && step_q == vpcf_pkg::C_MULK &&
					axis_q == vpcf_pkg::AXIS_FIRST);
				ctl.step_last = (step_q == vpcf_pkg::C_OUT);
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vpcf_pkg::ST_IDLE: begin
				if (item_xfer) begin
					state_d = item_ch.func ? vpcf_pkg::ST_CORR : vpcf_pkg::ST_PRED;
				end
			end
			vpcf_pkg::ST_PRED, vpcf_pkg::ST_CORR: begin
				if (ctl.advance && ctl.step_last && axis_q == vpcf_pkg::AXIS_LAST) begin
					state_d = vpcf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vpcf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vpcf_pkg::ST_IDLE;
			step_q  <= '0;
			axis_q  <= vpcf_pkg::AXIS_FIRST;
		end else begin
			state_q <= state_d;
			if (item_xfer) begin
				step_q <= '0;
				axis_q <= vpcf_pkg::AXIS_FIRST;
			end else if (ctl.advance) begin
				if (ctl.step_last) begin
					step_q <= '0;
					axis_q <= axis_q + 2'd1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == vpcf_pkg::ST_PRED) begin
			case (step_q)
				vpcf_pkg::P_MUL0, vpcf_pkg::P_MUL1, vpcf_pkg::P_MUL2: begin
					mul_a = vpcf_pkg::MA_W'(vec_q[col]);
					mul_b = vpcf_pkg::MB_W'($signed(
						rot_q[axis_q][{col, 4'b0000} +: vpcf_pkg::MAT_W]));
				end
				vpcf_pkg::P_TSHI: begin
					mul_a = vpcf_pkg::MA_W'($signed(s10_q[vpcf_pkg::S10_W-1:vpcf_pkg::SPLIT]));
					mul_b = $signed({1'b0, ts_q});
				end
				vpcf_pkg::P_TSLO: begin
					mul_a = vpcf_pkg::MA_W'(s10_q[vpcf_pkg::SPLIT-1:0]);
					mul_b = $signed({1'b0, ts_q});
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == vpcf_pkg::ST_CORR) begin
			case (step_q)
				vpcf_pkg::C_MULK: begin
					mul_a = vpcf_pkg::MA_W'(kept_q[axis_q]);
					mul_b = vpcf_pkg::MB_W'(w);
				end
				vpcf_pkg::C_MULR: begin
					mul_a = vpcf_pkg::MA_W'(vec_q[axis_q]);
					mul_b = vpcf_pkg::MB_W'(vpcf_pkg::W_ONE - w);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign prod = mul_a * mul_b;

	// datapath
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			rot_q[0] <= item_ch.rot_row0;
			rot_q[1] <= item_ch.rot_row1;
			rot_q[2] <= item_ch.rot_row2;
			vec_q[0] <= item_ch.vec_x;
			vec_q[1] <= item_ch.vec_y;
			vec_q[2] <= item_ch.vec_z;
		end
		if (ctl.advance && state_q == vpcf_pkg::ST_PRED) begin
			case (step_q)
				vpcf_pkg::P_MUL0: begin
					p_q <= prod;
				end
				vpcf_pkg::P_MUL1: begin
					p_q   <= prod;
					acc_q <= pterm_s;
				end
				vpcf_pkg::P_MUL2: begin
					p_q   <= prod;
					acc_q <= acc_q + pterm_s;
				end
				vpcf_pkg::P_SUM: begin
					acc_q <= acc_q + pterm_s + (neg ? grav_term : '0);
				end
				vpcf_pkg::P_SCALE: begin
					acc_q <= (acc_q <<< 6) + (acc_q <<< 5) + (acc_q <<< 2);
				end
				vpcf_pkg::P_S10: begin
					s10_q <= vpcf_pkg::S10_W'((acc_q + vpcf_pkg::RND20) >>> 20);
				end
				vpcf_pkg::P_TSHI: begin
					p_q <= prod;
				end
				vpcf_pkg::P_TSLO: begin
					p_q   <= prod;
					acc_q <= pterm <<< vpcf_pkg::SPLIT;
				end
				vpcf_pkg::P_PROD: begin
					acc_q <= acc_q + pterm;
				end
				vpcf_pkg::P_DELTA: begin
					acc_q <= (acc_q + vpcf_pkg::RND18) >>> 18;
				end
				default: begin
				end
			endcase
		end
		if (ctl.advance && state_q == vpcf_pkg::ST_CORR) begin
			case (step_q)
				vpcf_pkg::C_MULK: begin
					p_q <= prod;
				end
				vpcf_pkg::C_MULR: begin
					p_q   <= prod;
					acc_q <= pterm;
				end
				vpcf_pkg::C_SUM: begin
					acc_q <= acc_q + pterm;
				end
				vpcf_pkg::C_OUT: begin
					vel_q[axis_q] <= vpcf_pkg::sat32(
						vpcf_pkg::SUM_W'((acc_q + vpcf_pkg::RND16) >>> 16));
				end
				default: begin
				end
			endcase
		end
	end

	// kept velocity, output valid, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q[0]   <= '0;
			kept_q[1]   <= '0;
			kept_q[2]   <= '0;
			out_valid_q <= 1'b0;
			ts_q        <= vpcf_pkg::TS_RESET;
			bw_q        <= vpcf_pkg::BW_RESET;
			gr_q        <= vpcf_pkg::GR_RESET;
		end else begin
			if (ctl.advance && state_q == vpcf_pkg::ST_PRED && step_q == vpcf_pkg::P_KEEP) begin
				kept_q[axis_q] <= vpcf_pkg::sat32(vpcf_pkg::SUM_W'(acc_q) +
					vpcf_pkg::SUM_W'(kept_q[axis_q]));
			end
			if (ctl.advance && state_q == vpcf_pkg::ST_CORR && ctl.step_last &&
				axis_q == vpcf_pkg::AXIS_LAST) begin
				out_valid_q <= 1'b1;
			end else if (result_xfer) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_idx)
					vpcf_pkg::REG_TIME_STEP: ts_q <= cfg_data[vpcf_pkg::TS_W-1:0];
					vpcf_pkg::REG_BLEND:     bw_q <= cfg_data[vpcf_pkg::BW_W-1:0];
					vpcf_pkg::REG_GRAVITY:   gr_q <= cfg_data[vpcf_pkg::GR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	assign item_ch.ready   = ctl.item_ready;
	assign result_ch.valid = out_valid_q;
	assign result_ch.vel_x = vel_q[0];
	assign result_ch.vel_y = vel_q[1];
	assign result_ch.vel_z = vel_q[2];

`ifndef SYNTH
	a_result_from_correct: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == vpcf_pkg::ST_CORR))
		else $error("result raised outside a correct item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.advance && state_q == vpcf_pkg::ST_CORR && step_q == vpcf_pkg::C_OUT)
		|-> !out_valid_q)
		else $error("output written while a result is pending");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != vpcf_pkg::ST_IDLE) |-> (axis_q <= vpcf_pkg::AXIS_LAST))
		else $error("axis counter out of range");
`endif

endmodule

[dv/vpcf_tb_pkg.sv]
package vpcf_tb_pkg;

	typedef enum logic {
		FUNC_PREDICT = 1'b0,
		FUNC_CORRECT = 1'b1
	} item_func_e;

	localparam logic [vpcf_pkg::CFG_IDX_W-1:0] REG_UNUSED = vpcf_pkg::CFG_IDX_W'(3);

endpackage

[dv/velocity_filter_checker.sv]
module velocity_filter_checker
	import vpcf_pkg::*;
	import vpcf_tb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	vpcf_item_if                 item_ch,
	vpcf_result_if               result_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	output int unsigned          velocity_due_count,
	output int unsigned          mismatch_count
);

	typedef logic [2:0][VEC_W-1:0] velocity_t;

	localparam longint VEL_MAX = 64'sd2147483647;
	localparam longint VEL_MIN = -64'sd2147483648;

	logic [TS_W-1:0]          step_cfg;
	logic [BW_W-1:0]          weight_cfg;
	logic [GR_W-1:0]          gravity_cfg;
	logic signed [VEC_W-1:0]  kept [3];
	velocity_t                velocity_due [$];

	// half rounds up
	function automatic longint round_shift(input longint x, input int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [VEC_W-1:0] clamp32(input longint x);
		if (x > VEL_MAX)
			return VEL_MAX[VEC_W-1:0];
		if (x < VEL_MIN)
			return VEL_MIN[VEC_W-1:0];
		return x[VEC_W-1:0];
	endfunction

	function automatic void integrate_accel(input logic [ROW_W-1:0] r0, r1, r2,
		input logic signed [VEC_W-1:0] x, y, z);
		logic [ROW_W-1:0] rows [3];
		longint accel [3];
		longint sum;
		longint s10;
		longint delta;
		rows = '{r0, r1, r2};
		accel = '{longint'(x), longint'(y), longint'(z)};
		for (int r = 0; r < 3; r++) begin
			sum = 0;
			for (int c = 0; c < 3; c++)
				sum += longint'($signed(rows[r][MAT_W*c +: MAT_W])) * accel[c];
			if (r == 2) begin
				sum -= longint'(gravity_cfg) <<< GR_SH;
				sum = sum * -100;
			end else begin
				sum = sum * 100;
			end
			s10 = round_shift(sum, 20);
			delta = round_shift(s10 * longint'(step_cfg), 18);
			kept[r] = clamp32(longint'(kept[r]) + delta);
		end
	endfunction

	function automatic velocity_t blend_velocity(input logic signed [VEC_W-1:0] x, y, z);
		longint w;
		longint refv [3];
		velocity_t v;
		w = (weight_cfg > W_ONE) ? longint'(W_ONE) : longint'(weight_cfg);
		refv = '{longint'(x), longint'(y), longint'(z)};
		for (int i = 0; i < 3; i++)
			v[i] = clamp32(round_shift(w * longint'(kept[i]) + (longint'(W_ONE) - w) * refv[i], 16));
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		velocity_t   got;
		velocity_t   want;
		int unsigned pushed;
		int unsigned popped;
		int unsigned errs;
		string       field;
		if (!arst_n) begin
			step_cfg = TS_RESET;
			weight_cfg = BW_RESET;
			gravity_cfg = GR_RESET;
			kept = '{default: '0};
			velocity_due.delete();
			velocity_due_count <= 0;
			mismatch_count <= 0;
		end else begin
			pushed = 0;
			popped = 0;
			errs = 0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_TIME_STEP: step_cfg = cfg_data[TS_W-1:0];
					REG_BLEND:     weight_cfg = cfg_data[BW_W-1:0];
					REG_GRAVITY:   gravity_cfg = cfg_data[GR_W-1:0];
					default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready) begin
				if (item_ch.func == FUNC_CORRECT) begin
					velocity_due.push_back(blend_velocity(item_ch.vec_x, item_ch.vec_y,
						item_ch.vec_z));
					pushed = 1;
				end else begin
					integrate_accel(item_ch.rot_row0, item_ch.rot_row1, item_ch.rot_row2,
						item_ch.vec_x, item_ch.vec_y, item_ch.vec_z);
				end
			end
			if (result_ch.valid && result_ch.ready) begin
				if (velocity_due.size() == 0) begin
					$error("velocity transfer with no correct item outstanding");
					errs++;
				end else begin
					want = velocity_due.pop_front();
					popped = 1;
					got = {result_ch.vel_z, result_ch.vel_y, result_ch.vel_x};
					for (int i = 0; i < 3; i++) begin
						if (got[i] !== want[i]) begin
							field = (i == 0) ? "vel_x" : (i == 1) ? "vel_y" : "vel_z";
							$error("%s: expected %0d, got %0d", field, $signed(want[i]),
								$signed(got[i]));
							errs++;
						end
					end
				end
			end
			velocity_due_count <= velocity_due_count + pushed - popped;
			mismatch_count <= mismatch_count + errs;
		end
	end

endmodule

[dv/testbench.sv]
module testbench;
	import vpcf_pkg::*;
	import vpcf_tb_pkg::*;

	localparam logic [MAT_W-1:0]        ONE_Q14 = 16'h4000;
	localparam logic [MAT_W-1:0]        M_MAX   = 16'h7FFF;
	localparam logic [MAT_W-1:0]        M_MIN   = 16'h8000;
	localparam logic signed [VEC_W-1:0] V_MAX   = 32'sh7FFFFFFF;
	localparam logic signed [VEC_W-1:0] V_MIN   = 32'sh80000000;
	localparam int                      ITEMS_PER_PHASE = 66;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	int unsigned          sender_idle_pct;
	int unsigned          receiver_stall_pct;
	int unsigned          velocity_due_count;
	int unsigned          mismatch_count;

	vpcf_item_if   item_ch ();
	vpcf_result_if result_ch ();

	velocity_predict_correct_filter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (item_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	velocity_filter_checker velocity_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_ch            (item_ch),
		.result_ch          (result_ch),
		.cfg_we             (cfg_we),
		.cfg_idx            (cfg_idx),
		.cfg_data           (cfg_data),
		.velocity_due_count (velocity_due_count),
		.mismatch_count     (mismatch_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	function automatic logic [ROW_W-1:0] row_of(input logic [MAT_W-1:0] c0, c1, c2);
		return {c2, c1, c0};
	endfunction

	task automatic send_item(input item_func_e func, input logic [ROW_W-1:0] r0, r1, r2,
		input logic signed [VEC_W-1:0] x, y, z);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= func;
		item_ch.rot_row0 <= r0;
		item_ch.rot_row1 <= r1;
		item_ch.rot_row2 <= r2;
		item_ch.vec_x <= x;
		item_ch.vec_y <= y;
		item_ch.vec_z <= z;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	// mostly plausible attitude and motion, sometimes anything at all
	task automatic send_random();
		logic [ROW_W-1:0]        rows [3];
		logic signed [VEC_W-1:0] v [3];
		item_func_e              func;
		int unsigned             wild;
		int unsigned             span;
		func = ($urandom_range(99) < 60) ? FUNC_PREDICT : FUNC_CORRECT;
		wild = $urandom_range(99);
		span = (func == FUNC_PREDICT) ? (40 << 16) : (2000 << 16);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				rows[r][MAT_W*c +: MAT_W] = (wild < 10) ? MAT_W'($urandom) :
					MAT_W'($urandom_range(32768) - 16384);
		for (int i = 0; i < 3; i++)
			v[i] = (wild < 10) ? $urandom : VEC_W'($urandom_range(2 * span) - span);
		send_item(func, rows[0], rows[1], rows[2], v[0], v[1], v[2]);
	endtask

	// pause the sender until every velocity is back and the block has gone idle
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (velocity_due_count != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [ROW_W-1:0] ident [3];
		logic [ROW_W-1:0] all_max;
		logic [ROW_W-1:0] all_min;
		logic [CFG_W-1:0] ts;
		logic [CFG_W-1:0] bw;
		logic [CFG_W-1:0] gr;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_PREDICT;
		item_ch.rot_row0 = '0;
		item_ch.rot_row1 = '0;
		item_ch.rot_row2 = '0;
		item_ch.vec_x = '0;
		item_ch.vec_y = '0;
		item_ch.vec_z = '0;
		result_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_TIME_STEP;
		cfg_data = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		ident = '{row_of(ONE_Q14, '0, '0), row_of('0, ONE_Q14, '0), row_of('0, '0, ONE_Q14)};
		all_max = row_of(M_MAX, M_MAX, M_MAX);
		all_min = row_of(M_MIN, M_MIN, M_MIN);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_CORRECT, '0, '0, '0, 0, 0, 0);
		send_item(FUNC_CORRECT, '0, '0, '0, V_MAX, V_MIN, -1);
		send_item(FUNC_PREDICT, ident[0], ident[1], ident[2], 0, 0, VEC_W'(GR_RESET));
		send_item(FUNC_PREDICT, ident[0], ident[1], ident[2], 1 << 16, -(1 << 16), 3 << 16);
		send_item(FUNC_CORRECT, '0, '0, '0, 0, 0, 0);
		// drive kept velocity into both saturation limits
		send_item(FUNC_PREDICT, all_max, all_max, all_max, V_MAX, V_MAX, V_MAX);
		send_item(FUNC_PREDICT, all_max, all_max, all_max, V_MAX, V_MAX, V_MAX);
		send_item(FUNC_CORRECT, '0, '0, '0, V_MAX, V_MAX, V_MAX);
		send_item(FUNC_PREDICT, all_min, all_min, all_min, V_MAX, V_MAX, V_MAX);
		send_item(FUNC_CORRECT, '0, '0, '0, V_MIN, V_MIN, V_MIN);
		send_item(FUNC_PREDICT, row_of(M_MAX, M_MIN, 16'h0001), row_of(M_MIN, 16'h0001, M_MAX),
			row_of(16'h0001, M_MAX, M_MIN), V_MIN, V_MAX, 0);
		send_item(FUNC_CORRECT, '0, '0, '0, 12345 << 8, -(777 << 12), 1);
		settle();
		write_reg(REG_TIME_STEP, 24'hFFFFFF);
		write_reg(REG_BLEND, CFG_W'(17'h1FFFF));
		write_reg(REG_GRAVITY, CFG_W'(20'hFFFFF));
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send_item(FUNC_PREDICT, ident[0], ident[1], ident[2], 0, 0, 0);
		send_item(FUNC_CORRECT, '0, '0, '0, V_MIN, V_MAX, 0);
		settle();
		write_reg(REG_TIME_STEP, '0);
		write_reg(REG_BLEND, CFG_W'(W_ONE));
		write_reg(REG_GRAVITY, '0);
		send_item(FUNC_PREDICT, all_max, all_min, all_max, V_MIN, V_MAX, V_MIN);
		send_item(FUNC_CORRECT, '0, '0, '0, 1, 2, 3);
		settle();
		write_reg(REG_BLEND, '0);
		send_item(FUNC_CORRECT, '0, '0, '0, V_MAX, V_MIN, 7);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					ts = CFG_W'(TS_RESET);
					bw = CFG_W'(BW_RESET);
					gr = CFG_W'(GR_RESET);
				end
				1: begin
					ts = 24'hFFFFFF;
					bw = CFG_W'(W_ONE);
					gr = '0;
				end
				2: begin
					ts = 24'd1;
					bw = '0;
					gr = CFG_W'(20'hFFFFF);
				end
				3: begin
					ts = 24'd4194304;
					bw = CFG_W'(17'h1FFFF);
					gr = CFG_W'(GR_RESET);
				end
				default: begin
					ts = CFG_W'($urandom_range(1 << 20));
					bw = CFG_W'($urandom_range(17'h1FFFF));
					gr = CFG_W'($urandom_range(20'hFFFFF));
				end
			endcase
			write_reg(REG_TIME_STEP, ts);
			write_reg(REG_BLEND, bw);
			write_reg(REG_GRAVITY, gr);
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 53;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 53;
				end
				default: begin
					sender_idle_pct = 9;
					receiver_stall_pct = 9;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_random();
				if ($urandom_range(99) < 3)
					settle();
			end
			settle();
		end

		if (mismatch_count == 0 && velocity_due_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Some tests failed");
		$finish;
	end

endmodule
